// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on the rising edge of clk, masked while rst_n is low.
// The enclosing module must have clk and rst_n.

// Same-cycle implication.
`define CHK_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== src/u2rd_pkg.sv =====
package u2rd_pkg;

    localparam int          MAX_DIGITS_DEF   = 64;
    localparam logic [4:0]  MAX_RADIX        = 5'd16;
    localparam logic [4:0]  MIN_RADIX        = 5'd2;
    localparam logic [7:0]  ZERO_CHAR        = 8'h30;

    localparam logic [4:0]  RADIX_RESET      = 5'd10;
    localparam logic [63:0] CHARS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [63:0] CHARS_HIGH_RESET = 64'h6665646362613938;

    typedef enum logic [1:0] {
        CFG_RADIX      = 2'd0,
        CFG_CHARS_LOW  = 2'd1,
        CFG_CHARS_HIGH = 2'd2
    } cfg_idx_t;

    // divider request / response
    typedef struct packed {
        logic       start;
        logic [4:0] radix;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [3:0]  rem;
        logic [63:0] quo;
    } div_rsp_t;

    // clamp the radix register into 2..MAX_RADIX
    function automatic logic [4:0] eff_radix(input logic [4:0] r);
        logic [4:0] res;
        res = r;
        if (r < MIN_RADIX)
        begin
            res = MIN_RADIX;
        end
        else if (r > MAX_RADIX)
        begin
            res = MAX_RADIX;
        end
        return res;
    endfunction

    function automatic logic [7:0] digit_to_char(input logic [3:0] d,
                                                 input logic [63:0] lo,
                                                 input logic [63:0] hi);
        logic [63:0] w;
        w = d[3] ? hi : lo;
        return w[{d[2:0], 3'b000} +: 8];
    endfunction

endpackage

// ===== src/unsigned_to_radix_digits.sv =====
// Converts one 64-bit unsigned word into its digit characters in radix 2..16
// (radix register, values outside clamped), most significant digit first,
// each digit mapped through the 16-byte character table in chars_low_reg/
// chars_high_reg; m_tlast marks the final character, and a zero word gives
// the single character '0' whatever the table holds. Each digit comes from
// restoring division in the divider, one dividend byte per cycle, followed
// by a handoff that writes the remainder into the digit memory; then the
// characters stream out of the digit memory through a registered read at
// one per cycle under m_tready. The next word is taken once the last digit
// read is issued. Configuration must be written only while no word is in
// flight; the block itself does not enforce this. cfg_ready is always high
// and unknown indexes are dropped.

`include "assert_macros.svh"

module unsigned_to_radix_digits #(
    parameter int MAX_DIGITS = u2rd_pkg::MAX_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [63:0] value

    // character words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] digit_char
    output logic        m_tlast,     // last_char

    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [4:0]  radix_reg;
    logic [63:0] chars_low_reg;
    logic [63:0] chars_high_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= u2rd_pkg::RADIX_RESET;
            chars_low_reg  <= u2rd_pkg::CHARS_LOW_RESET;
            chars_high_reg <= u2rd_pkg::CHARS_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                u2rd_pkg::CFG_RADIX:      radix_reg      <= cfg_data[4:0];
                u2rd_pkg::CFG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                u2rd_pkg::CFG_CHARS_HIGH: chars_high_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------------
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;     // digits written so far
    logic [CW-1:0]  rd_left_reg, rd_left_next; // digit reads still to issue
    logic           zero_item_reg, zero_item_next;

    // read in flight / landed but not yet moved to the output
    logic           pend_reg, pend_next;
    logic           pend_last_reg, pend_last_next;
    logic           pend_zero_reg, pend_zero_next;

    logic           out_valid_reg, out_valid_next;
    logic [7:0]     out_char_reg, out_char_next;
    logic           out_last_reg, out_last_next;

    u2rd_pkg::div_req_t div_req;
    u2rd_pkg::div_rsp_t div_rsp;
    logic [63:0]        div_dividend;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [3:0]     rd_data;

    logic [CW-1:0]  count_inc;
    logic [CW-1:0]  rd_idx;
    logic           out_load;
    logic           in_take;

    assign in_take   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign count_inc = count_reg + CW'(1);
    assign rd_idx    = rd_left_reg - CW'(1);
    assign wr_addr   = count_reg[AW-1:0];
    assign rd_addr   = rd_idx[AW-1:0];

    // landed digit moves out when the output slot is free or being taken
    assign out_load  = pend_reg && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_left_next   = rd_left_reg;
        zero_item_next = zero_item_reg;
        div_req.start  = 1'b0;
        div_req.radix  = u2rd_pkg::eff_radix(radix_reg);
        div_dividend   = s_tdata;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    // a zero word still runs one division, giving one digit
                    div_req.start  = 1'b1;
                    count_next     = '0;
                    zero_item_next = (s_tdata == 64'd0);
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    wr_en      = 1'b1;
                    count_next = count_inc;
                    if ((div_rsp.quo == 64'd0) || (count_inc == CW'(MAX_DIGITS)))
                    begin
                        rd_left_next = count_inc;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_dividend  = div_rsp.quo;
                    end
                end
            end
            ST_EMIT:
            begin
                // reads run highest digit first, one per cycle if unstalled
                if ((rd_left_reg != '0) && (!pend_reg || out_load))
                begin
                    rd_en        = 1'b1;
                    rd_left_next = rd_idx;
                    if (rd_left_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        pend_zero_next = pend_zero_reg;
        if (rd_en)
        begin
            pend_next      = 1'b1;
            pend_last_next = (rd_left_reg == CW'(1));
            pend_zero_next = zero_item_reg;
        end
        else if (out_load)
        begin
            pend_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = pend_zero_reg ? u2rd_pkg::ZERO_CHAR :
                             u2rd_pkg::digit_to_char(rd_data, chars_low_reg,
                                                     chars_high_reg);
            out_last_next  = pend_last_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_left_reg   <= '0;
            zero_item_reg <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_left_reg   <= rd_left_next;
            zero_item_reg <= zero_item_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_last_reg <= pend_last_next;
        pend_zero_reg <= pend_zero_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // ---------------------------------------------------------------------
    // Divider and digit memory
    // ---------------------------------------------------------------------
    u2rd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .rsp      (div_rsp)
    );

    u2rd_store #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (div_rsp.rem),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `CHK_SAME(a_done_in_div, div_rsp.done, state_reg == ST_DIV)
    `CHK_SAME(a_emit_has_reads, state_reg == ST_EMIT, rd_left_reg != '0)
    `CHK_SAME(a_no_read_over_pend, pend_reg && !out_load, !rd_en)
    `CHK_SAME(a_count_bound, state_reg == ST_DIV, count_reg < CW'(MAX_DIGITS))

endmodule

// ===== src/u2rd_store.sv =====
module u2rd_store #(
    parameter int DEPTH = u2rd_pkg::MAX_DIGITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [3:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [3:0]    rd_data
);

    logic [3:0] mem [DEPTH];
    logic [3:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/u2rd_div.sv =====
`include "assert_macros.svh"

module u2rd_div (
    input  logic               clk,
    input  logic               rst_n,
    input  u2rd_pkg::div_req_t req,
    input  logic [63:0]        dividend,
    output u2rd_pkg::div_rsp_t rsp
);

    // Restoring division, one dividend byte per cycle.
    // Quotient bits shift in at the bottom as dividend bits leave the top.
    logic [63:0] work_reg, work_next;
    logic [3:0]  rem_reg, rem_next;
    logic [4:0]  radix_reg, radix_next;
    logic [2:0]  step_reg, step_next;
    logic        active_reg, active_next;
    logic        done_reg, done_next;

    logic [7:0]  qbyte;
    logic [3:0]  rem_step;

    always_comb
    begin
        logic [4:0] r;
        logic [3:0] acc;
        acc   = rem_reg;
        qbyte = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {acc, work_reg[56 + i]};
            if (r >= radix_reg)
            begin
                r        = r - radix_reg;
                qbyte[i] = 1'b1;
            end
            acc = r[3:0];
        end
        rem_step = acc;
    end

    always_comb
    begin
        work_next   = work_reg;
        rem_next    = rem_reg;
        radix_next  = radix_reg;
        step_next   = step_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            work_next   = dividend;
            rem_next    = '0;
            radix_next  = req.radix;
            step_next   = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            work_next = {work_reg[55:0], qbyte};
            rem_next  = rem_step;
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd7)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;
    assign rsp.quo  = work_reg;

    `CHK_NEXT(a_start_runs, req.start, active_reg && step_reg == 3'd0)
    `CHK_SAME(a_done_idle, done_reg, !active_reg)

endmodule
